// ===== rtl/lgi_pkg.sv =====
// ----------------------------------------------------------------------------
// lgi_pkg
// Shared constants, register indexes and controller/datapath bundles for the
// Lagrange interpolator.
// ----------------------------------------------------------------------------
package lgi_pkg;

    localparam int NODES     = 16;
    localparam int NIDX_W    = 4;
    localparam int CNT_W     = 5;
    localparam int WORD_W    = 32;
    localparam int FB        = 24;
    localparam int MAG_W     = 62;
    localparam int ERR_W     = 48;
    localparam int QIDX_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int NCFG_W    = 5;
    localparam int QP_W      = QIDX_W + 1 + WORD_W;
    localparam int NUM_W     = 50;
    localparam int DEN_W     = 37;
    localparam int DIV_W     = NUM_W + FB;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_STEP  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_STEP = 2'd3;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic             load_we;
        logic             q_start;
        logic             basis_init;
        logic             div_start;
        logic             mul_start;
        logic             mul_term;
        logic             basis_update;
        logic             acc_add;
        logic             finish;
        logic [CNT_W-1:0] i_idx;
        logic [CNT_W-1:0] j_idx;
    } lgi_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] n_eff;
        logic             skip;
        logic             div_done;
        logic             mul_done;
    } lgi_stat_t;

endpackage

// ===== rtl/lagrange_interpolator_unit.sv =====
// ----------------------------------------------------------------------------
// lagrange_interpolator_unit
// Lagrange interpolation over a uniform node grid in signed Q8.24, with a
// saturating running absolute-error sum.
// ----------------------------------------------------------------------------
//   channel  | signals                                        | transfer
//   ---------+------------------------------------------------+----------------
//   in       | in_valid/in_ready, action, node_index, sample,  | valid & ready
//            | query_index, reference_value                   |
//   out      | out_valid/out_ready, interpolated_value,       | valid & ready
//            | error_sum                                      |
//   cfg      | cfg_write, cfg_index, cfg_data                 | cfg_write high
//
// A load transaction produces nothing. A query's run time for n nodes in
// use is set by the serial divider (one quotient bit per cycle, 74 per
// factor) and the partial-product multiplier (four partial products), both
// shared by every node pair. Reset returns control and configuration to
// defaults and clears the error accumulator; the sample store and the result
// registers are not cleared. A pending result is held in the output register
// while loads are still taken; a finished query waits there for out_ready.
// ----------------------------------------------------------------------------
module lagrange_interpolator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic [lgi_pkg::NIDX_W-1:0]    node_index,
    input  logic [lgi_pkg::WORD_W-1:0]    sample,
    input  logic [lgi_pkg::QIDX_W-1:0]    query_index,
    input  logic [lgi_pkg::WORD_W-1:0]    reference_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lgi_pkg::WORD_W-1:0]    interpolated_value,
    output logic [lgi_pkg::ERR_W-1:0]     error_sum,
    input  logic                          cfg_write,
    input  logic [lgi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lgi_pkg::WORD_W-1:0]    cfg_data
);
    import lgi_pkg::*;

    lgi_cmd_t  cmd;
    lgi_stat_t stat;

    // sequence the node-pair walk and own both handshakes
    lgi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // hold samples and configuration, run the arithmetic
    lgi_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .node_index         (node_index),
        .sample             (sample),
        .query_index        (query_index),
        .reference_value    (reference_value),
        .interpolated_value (interpolated_value),
        .error_sum          (error_sum)
    );

endmodule

// ===== rtl/lgi_div.sv =====
// ----------------------------------------------------------------------------
// lgi_div
// Restoring divider, one quotient bit per cycle: (num << FB) / den on
// magnitudes, quotient saturated to the wide magnitude range.
// ----------------------------------------------------------------------------
module lgi_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lgi_pkg::NUM_W-1:0]  num_mag,
    input  logic [lgi_pkg::DEN_W-1:0]  den_mag,
    output logic                       done,
    output logic [lgi_pkg::MAG_W-1:0]  quo
);
    import lgi_pkg::*;

    localparam int DCNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  dvd_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [DEN_W:0]    rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DEN_W:0]    rem_sh;
    logic              fits;

    always_comb
    begin
        rem_sh = {rem_reg[DEN_W-1:0], dvd_reg[DIV_W-1]};
        fits   = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {num_mag, {FB{1'b0}}};
            den_reg <= den_mag;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
        end
    end

    assign done = done_reg;
    assign quo  = (|quo_reg[DIV_W-1:MAG_W]) ? {MAG_W{1'b1}} : quo_reg[MAG_W-1:0];

endmodule

// ===== rtl/lgi_mul.sv =====
// ----------------------------------------------------------------------------
// lgi_mul
// Fixed-point magnitude multiplier: four 32x32 partial products formed in
// turn and accumulated, result shifted down by FB and saturated.
// ----------------------------------------------------------------------------
module lgi_mul (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [lgi_pkg::MAG_W-1:0] a,
    input  logic [lgi_pkg::MAG_W-1:0] b,
    output logic                      done,
    output logic [lgi_pkg::MAG_W-1:0] prod
);
    import lgi_pkg::*;

    localparam int HALF  = 32;
    localparam int HI_W  = MAG_W - HALF;
    localparam int ACC_W = 2 * MAG_W;
    localparam int RES_W = ACC_W - FB;

    logic [MAG_W-1:0]  a_reg;
    logic [MAG_W-1:0]  b_reg;
    logic [2*HALF-1:0] pp_reg;
    logic [1:0]        sh_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [2:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [HALF-1:0]   a_part;
    logic [HALF-1:0]   b_part;
    logic [ACC_W-1:0]  pp_ext;
    logic [RES_W-1:0]  res;

    always_comb
    begin
        a_part = cnt_reg[1] ? HALF'(a_reg[MAG_W-1:HALF]) : a_reg[HALF-1:0];
        b_part = cnt_reg[0] ? HALF'(b_reg[MAG_W-1:HALF]) : b_reg[HALF-1:0];
        pp_ext = ACC_W'(pp_reg) << {sh_reg, 5'b0};
        res    = acc_reg[ACC_W-1:FB];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 3'd4)
            begin
                pp_reg <= a_part * b_part;
                sh_reg <= 2'(cnt_reg[1]) + 2'(cnt_reg[0]);
            end
            if (cnt_reg != 3'd0)
                acc_reg <= acc_reg + pp_ext;
        end
    end

    assign done = done_reg;
    assign prod = (|res[RES_W-1:MAG_W]) ? {MAG_W{1'b1}} : res[MAG_W-1:0];

    logic unused_hi;
    assign unused_hi = ^HI_W;

endmodule

// ===== rtl/lgi_dp.sv =====
// ----------------------------------------------------------------------------
// lgi_dp
// Datapath: configuration registers, sample store, factor operands, basis
// and sum registers, error accumulator and result registers.
// ----------------------------------------------------------------------------
module lgi_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lgi_pkg::lgi_cmd_t             cmd,
    output lgi_pkg::lgi_stat_t            stat,
    input  logic                          cfg_write,
    input  logic [lgi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lgi_pkg::WORD_W-1:0]    cfg_data,
    input  logic [lgi_pkg::NIDX_W-1:0]    node_index,
    input  logic [lgi_pkg::WORD_W-1:0]    sample,
    input  logic [lgi_pkg::QIDX_W-1:0]    query_index,
    input  logic [lgi_pkg::WORD_W-1:0]    reference_value,
    output logic [lgi_pkg::WORD_W-1:0]    interpolated_value,
    output logic [lgi_pkg::ERR_W-1:0]     error_sum
);
    import lgi_pkg::*;

    localparam logic signed [63:0] SAT_POS = 64'(signed'({1'b0, {MAG_W{1'b1}}}));
    localparam logic signed [63:0] SAT_NEG = -SAT_POS;
    localparam logic signed [63:0] V_MAX   = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] V_MIN   = -64'sh0000_0000_8000_0000;

    logic [NCFG_W-1:0]        node_count_reg;
    logic signed [WORD_W-1:0] grid_step_reg;
    logic signed [WORD_W-1:0] query_step_reg;
    logic signed [WORD_W-1:0] grid_start_reg;
    logic [WORD_W-1:0]        samples_mem [NODES];
    logic signed [WORD_W-1:0] sample_rd_reg;
    logic signed [QP_W-1:0]   qprod_reg;
    logic signed [WORD_W-1:0] ref_reg;
    logic [MAG_W-1:0]         basis_mag_reg;
    logic                     basis_neg_reg;
    logic                     div_neg_reg;
    logic                     term_neg_reg;
    logic signed [63:0]       acc_reg;
    logic [ERR_W-1:0]         err_reg;
    logic [WORD_W-1:0]        value_reg;
    logic [ERR_W-1:0]         esum_reg;

    logic signed [NUM_W-1:0]  num_s;
    logic signed [NUM_W-1:0]  jstep;
    logic signed [CNT_W:0]    dij;
    logic signed [DEN_W:0]    den_s;
    logic [NUM_W-1:0]         num_mag;
    logic [DEN_W:0]           den_abs;
    logic [WORD_W:0]          s_ext;
    logic [WORD_W:0]          s_mag;
    logic [MAG_W-1:0]         mul_a;
    logic [MAG_W-1:0]         mul_b;
    logic                     div_done;
    logic                     mul_done;
    logic [MAG_W-1:0]         quo;
    logic [MAG_W-1:0]         prod;
    logic signed [63:0]       term_s;
    logic signed [63:0]       sum_s;
    logic signed [63:0]       acc_next;
    logic signed [63:0]       value_s;
    logic signed [WORD_W+1:0] diff_s;
    logic [WORD_W:0]          diff_mag;
    logic [ERR_W:0]           err_wide;
    logic [ERR_W-1:0]         err_next;
    logic [NCFG_W-1:0]        n_eff;

    always_comb
    begin
        n_eff = (node_count_reg > NCFG_W'(NODES)) ? NCFG_W'(NODES) : node_count_reg;
        jstep = NUM_W'($signed({1'b0, cmd.j_idx})) * NUM_W'(grid_step_reg);
        num_s = NUM_W'(qprod_reg) - jstep;
        dij   = $signed({1'b0, cmd.i_idx}) - $signed({1'b0, cmd.j_idx});
        den_s = (DEN_W+1)'(dij) * (DEN_W+1)'(grid_step_reg);
        num_mag = num_s[NUM_W-1] ? NUM_W'(-num_s) : NUM_W'(num_s);
        den_abs = den_s[DEN_W] ? (DEN_W+1)'(-den_s) : (DEN_W+1)'(den_s);

        s_ext = {sample_rd_reg[WORD_W-1], sample_rd_reg};
        s_mag = s_ext[WORD_W] ? -s_ext : s_ext;
        mul_a = cmd.mul_term ? MAG_W'(s_mag) : basis_mag_reg;
        mul_b = cmd.mul_term ? basis_mag_reg : quo;

        term_s = term_neg_reg ? -64'(signed'({1'b0, prod})) : 64'(signed'({1'b0, prod}));
        sum_s  = acc_reg + term_s;
        if (sum_s > SAT_POS)
            acc_next = SAT_POS;
        else if (sum_s < SAT_NEG)
            acc_next = SAT_NEG;
        else
            acc_next = sum_s;

        if (acc_reg > V_MAX)
            value_s = V_MAX;
        else if (acc_reg < V_MIN)
            value_s = V_MIN;
        else
            value_s = acc_reg;
        diff_s   = (WORD_W+2)'(value_s) - (WORD_W+2)'(ref_reg);
        diff_mag = diff_s[WORD_W+1] ? (WORD_W+1)'(-diff_s) : (WORD_W+1)'(diff_s);
        err_wide = {1'b0, err_reg} + (ERR_W+1)'(diff_mag);
        err_next = err_wide[ERR_W] ? {ERR_W{1'b1}} : err_wide[ERR_W-1:0];
    end

    lgi_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .num_mag (num_mag),
        .den_mag (den_abs[DEN_W-1:0]),
        .done    (div_done),
        .quo     (quo)
    );

    lgi_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (prod)
    );

    // configuration and error accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NCFG_W'(2);
            grid_start_reg <= '0;
            grid_step_reg  <= WORD_W'(1) << FB;
            query_step_reg <= WORD_W'(1) << FB;
            err_reg        <= '0;
        end
        else if (cfg_write)
        begin
            err_reg <= '0;
            unique case (cfg_index)
                CFG_NODE_COUNT: node_count_reg <= cfg_data[NCFG_W-1:0];
                CFG_GRID_START: grid_start_reg <= cfg_data;
                CFG_GRID_STEP:  grid_step_reg  <= cfg_data;
                CFG_QUERY_STEP: query_step_reg <= cfg_data;
                default:        err_reg        <= err_reg;
            endcase
        end
        else if (cmd.finish)
        begin
            err_reg <= err_next;
        end
    end

    // sample store
    always_ff @(posedge clk)
    begin
        if (cmd.load_we)
            samples_mem[node_index] <= sample;
        if (cmd.basis_init)
            sample_rd_reg <= samples_mem[cmd.i_idx[NIDX_W-1:0]];
    end

    // query working registers
    always_ff @(posedge clk)
    begin
        if (cmd.q_start)
        begin
            qprod_reg <= QP_W'($signed({1'b0, query_index})) * QP_W'(query_step_reg);
            ref_reg   <= reference_value;
            acc_reg   <= '0;
        end
        if (cmd.basis_init)
        begin
            basis_mag_reg <= MAG_W'(1) << FB;
            basis_neg_reg <= 1'b0;
        end
        if (cmd.div_start)
            div_neg_reg <= num_s[NUM_W-1] ^ den_s[DEN_W];
        if (cmd.mul_start)
            term_neg_reg <= sample_rd_reg[WORD_W-1] ^ basis_neg_reg;
        if (cmd.basis_update)
        begin
            basis_mag_reg <= prod;
            basis_neg_reg <= basis_neg_reg ^ div_neg_reg;
        end
        if (cmd.acc_add)
            acc_reg <= acc_next;
        if (cmd.finish)
        begin
            value_reg <= value_s[WORD_W-1:0];
            esum_reg  <= err_next;
        end
    end

    assign stat.n_eff    = n_eff;
    assign stat.skip     = (grid_step_reg == '0) && (n_eff != NCFG_W'(1));
    assign stat.div_done = div_done;
    assign stat.mul_done = mul_done;

    assign interpolated_value = value_reg;
    assign error_sum          = esum_reg;

    logic unused_start;
    assign unused_start = ^grid_start_reg;

endmodule

// ===== rtl/lgi_ctrl.sv =====
// ----------------------------------------------------------------------------
// lgi_ctrl
// Controller: walks node pairs for a query and sequences divider, multiplier
// and accumulation; owns the input and output handshakes.
// ----------------------------------------------------------------------------
module lgi_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    output logic               out_valid,
    input  logic               out_ready,
    input  lgi_pkg::lgi_stat_t stat,
    output lgi_pkg::lgi_cmd_t  cmd
);
    import lgi_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_I_LOOP,
        ST_J_LOOP,
        ST_DIV,
        ST_MUL,
        ST_TERM,
        ST_FINISH
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] j_reg;
    logic             out_valid_reg;
    logic             accept;
    logic             out_free;

    always_comb
    begin
        accept   = in_valid && (state_reg == ST_IDLE);
        out_free = !out_valid_reg || out_ready;
        cmd              = '0;
        cmd.i_idx        = i_reg;
        cmd.j_idx        = j_reg;
        cmd.load_we      = accept && (action == ACT_LOAD);
        cmd.q_start      = accept && (action == ACT_QUERY);
        unique case (state_reg)
            ST_I_LOOP:
                cmd.basis_init = !stat.skip && (i_reg != stat.n_eff);
            ST_J_LOOP:
            begin
                if (j_reg == stat.n_eff)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_term  = 1'b1;
                end
                else if (j_reg != i_reg)
                    cmd.div_start = 1'b1;
            end
            ST_DIV:
                cmd.mul_start = stat.div_done;
            ST_MUL:
                cmd.basis_update = stat.mul_done;
            ST_TERM:
                cmd.acc_add = stat.mul_done;
            ST_FINISH:
                cmd.finish = out_free;
            default:
                cmd.finish = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (action == ACT_QUERY))
                    begin
                        i_reg     <= '0;
                        state_reg <= ST_I_LOOP;
                    end
                end
                ST_I_LOOP:
                begin
                    if (stat.skip || (i_reg == stat.n_eff))
                        state_reg <= ST_FINISH;
                    else
                    begin
                        j_reg     <= '0;
                        state_reg <= ST_J_LOOP;
                    end
                end
                ST_J_LOOP:
                begin
                    if (j_reg == stat.n_eff)
                        state_reg <= ST_TERM;
                    else if (j_reg == i_reg)
                        j_reg <= j_reg + 1'b1;
                    else
                        state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (stat.div_done)
                        state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    if (stat.mul_done)
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_J_LOOP;
                    end
                end
                ST_TERM:
                begin
                    if (stat.mul_done)
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_I_LOOP;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/lgi_checker.sv =====
// ----------------------------------------------------------------------------
// lgi_checker
// Port-level checks for the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module lgi_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       action,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [lgi_pkg::WORD_W-1:0] interpolated_value,
    input logic [lgi_pkg::ERR_W-1:0]  error_sum
);
    import lgi_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(interpolated_value)
            && $stable(error_sum))
        else $error("result changed while stalled");

    // a query transaction makes the block busy
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (action == ACT_QUERY) |=> !in_ready)
        else $error("input ready right after a query");

    // a load transaction leaves the block ready again in the next cycle
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (action == ACT_LOAD) |=> in_ready)
        else $error("load did not complete in one cycle");

    // a new result only appears from a busy block
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while idle");

endmodule

bind lagrange_interpolator_unit lgi_checker u_lgi_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .action             (action),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .interpolated_value (interpolated_value),
    .error_sum          (error_sum)
);
